### rtl/int_to_decimal_ascii_core_defines.svh
// Assertion macros for the integer-to-decimal core.
// No dependencies; included by modules that carry assertions.
`ifndef INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ITDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/itda_pkg.sv
// Shared types and constants for the integer-to-decimal core.
// No dependencies.
`timescale 1ns / 1ps

package itda_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 6;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BITCNT_W   = $clog2(VALUE_W + 1);
    localparam int DIGCNT_W   = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_step;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic one_left;
        logic negative;
        logic out_free;
    } sts_t;

endpackage

### rtl/itda_ctrl.sv
// Controller FSM: sequences load, binary-to-BCD steps, leading-zero skip and emission.
// Depends on itda_pkg.
`timescale 1ns / 1ps

module itda_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  itda_pkg::sts_t sts,
    output itda_pkg::cmd_t cmd
);
    import itda_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (sts.conv_done)
                begin
                    state_next = ST_SKIP;
                end
                else
                begin
                    cmd.conv_step = 1'b1;
                end
            end
            ST_SKIP:
            begin
                if (sts.top_zero && !sts.one_left)
                begin
                    cmd.skip_step = 1'b1;
                end
                else if (sts.negative)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (sts.one_left)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

### rtl/itda_dp.sv
// Datapath: magnitude and BCD shift registers, digit counter and output register.
// Depends on itda_pkg and int_to_decimal_ascii_core_defines.svh.
`timescale 1ns / 1ps
`include "int_to_decimal_ascii_core_defines.svh"

module itda_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [itda_pkg::VALUE_W-1:0]  value,
    input  itda_pkg::cmd_t                cmd,
    output itda_pkg::sts_t                sts,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [itda_pkg::CHAR_W-1:0]   character,
    output logic                          last
);
    import itda_pkg::*;

    logic [VALUE_W-1:0]  mag_reg;
    logic [VALUE_W-1:0]  mag_next;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BCD_W-1:0]    bcd_next;
    logic [BITCNT_W-1:0] bit_cnt_reg;
    logic [BITCNT_W-1:0] bit_cnt_next;
    logic [DIGCNT_W-1:0] dig_cnt_reg;
    logic [DIGCNT_W-1:0] dig_cnt_next;
    logic                neg_reg;
    logic                neg_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CHAR_W-1:0]   char_reg;
    logic [CHAR_W-1:0]   char_next;
    logic                last_reg;
    logic                last_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic [3:0]          top_digit;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    always_comb
    begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        neg_next       = neg_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.load)
        begin
            neg_next     = value[VALUE_W-1];
            mag_next     = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
            bcd_next     = '0;
            bit_cnt_next = '0;
            dig_cnt_next = DIGCNT_W'(NUM_DIGITS);
        end
        if (cmd.conv_step)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
            mag_next     = {mag_reg[VALUE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        if (cmd.skip_step || cmd.emit_digit)
        begin
            bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end
        if (cmd.emit_sign)
        begin
            out_valid_next = 1'b1;
            char_next      = CHAR_MINUS;
            last_next      = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
            char_next      = CHAR_ZERO + {2'b00, top_digit};
            last_next      = (dig_cnt_reg == DIGCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        neg_reg     <= neg_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign sts.conv_done = (bit_cnt_reg == BITCNT_W'(VALUE_W));
    assign sts.top_zero  = (top_digit == 4'd0);
    assign sts.one_left  = (dig_cnt_reg == DIGCNT_W'(1));
    assign sts.negative  = neg_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

    `ITDA_ASSERT_NOW(a_emit_out_free, (cmd.emit_digit || cmd.emit_sign), (!out_valid_reg || !out_stall), "emit while output held")
    `ITDA_ASSERT_NOW(a_conv_bound, cmd.conv_step, (bit_cnt_reg < BITCNT_W'(VALUE_W)), "conversion step past last bit")
    `ITDA_ASSERT_NOW(a_digit_left, (cmd.emit_digit || cmd.skip_step), (dig_cnt_reg != '0), "digit count underflow")
    `ITDA_ASSERT_NEXT(a_emit_valid, (cmd.emit_digit || cmd.emit_sign), out_valid_reg, "emitted character not presented")

endmodule

### rtl/int_to_decimal_ascii_core.sv
// Signed 32-bit integer to decimal ASCII, one character per output transfer.
// Per item: a load, one binary-to-BCD shift per magnitude bit, an end-of-conversion step,
// leading-zero skips, a skip-exit step, a sign character when negative, then the digit issues;
// skips and digit issues together cover all ten digit positions. Sign and digit issues wait
// while the output is stalled, and the next item is accepted only after its last character is issued.
// Asynchronous active-low reset clears the controller state and the output valid.
`timescale 1ns / 1ps

module int_to_decimal_ascii_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [itda_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [itda_pkg::CHAR_W-1:0]   character,
    output logic                          last
);
    import itda_pkg::*;

    cmd_t cmd;
    sts_t sts;

    itda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    itda_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

endmodule
